[sv/qrs_pkg.sv]
// Quadratic root solver package: widths, item and result types, shared helpers.
// No dependencies; imported by every qrs_* module and the top level.
`default_nettype none

package qrs_pkg;

  localparam int VW     = 32;
  localparam int FB     = 16;
  localparam int TOL_W  = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  localparam int PROD_W  = 2 * VW;
  localparam int D_W     = 2 * VW + 2;
  localparam int SQ_W    = D_W / 2;
  localparam int SQR_W   = SQ_W + 2;
  localparam int NUM_W   = SQ_W + 2;
  localparam int DEN_W   = VW + 2;
  localparam int NMAG_W  = NUM_W - 1;
  localparam int DMAG_W  = DEN_W - 1;
  localparam int NM_W    = NMAG_W + FB;
  localparam int QB      = VW;
  localparam int REM_W   = DMAG_W + 1;
  localparam int CMP_W   = DMAG_W + QB;
  localparam int DIV_LAT = QB + 2;

  localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_ALL  = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ALL,
    KIND_LIN,
    KIND_LIN_ZERO,
    KIND_ONE,
    KIND_TWO
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
    logic signed [VW-1:0] c;
    logic [D_W-1:0]       rad;
  } item_t;

  typedef struct packed {
    logic          valid;
    logic [1:0]    count;
    logic [VW-1:0] hi;
    logic [VW-1:0] lo;
    logic          ovf;
  } result_t;

  function automatic logic near_zero(logic [VW-1:0] v, logic [TOL_W-1:0] tol);
    logic [VW-1:0] mag;
    mag = v[VW-1] ? -v : v;
    return mag < VW'(tol);
  endfunction

endpackage

`default_nettype wire

[sv/qrs_front.sv]
// Front end: accepts coefficient sets, forms b*b - 4ac and classifies the case.
// Depends on qrs_pkg.
`default_nettype none

module qrs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic signed [qrs_pkg::VW-1:0] coef_square_i,
  input  logic signed [qrs_pkg::VW-1:0] coef_linear_i,
  input  logic signed [qrs_pkg::VW-1:0] coef_free_i,
  input  logic [qrs_pkg::TOL_W-1:0]     tol_i,
  input  logic                          stall_i,
  output logic                          valid_o,
  output qrs_pkg::item_t                item_o
);
  import qrs_pkg::*;

  logic                     en;
  logic                     v1_q, v2_q, v3_q;
  logic signed [VW-1:0]     a1_q, b1_q, c1_q, a2_q, b2_q, c2_q;
  logic signed [PROD_W-1:0] ac1_q, bb1_q;
  logic                     nza1_q, nzb1_q, nzc1_q, nza2_q, nzb2_q, nzc2_q;
  logic signed [D_W-1:0]    d2_q;
  logic [D_W-1:0]           dmag;
  logic                     dzero;
  kind_e                    kind_d;
  item_t                    item_q;

  assign en = !stall_i;

  always_comb begin
    dmag  = d2_q[D_W-1] ? -d2_q : d2_q;
    dzero = dmag < (D_W'(tol_i) << FB);
    if (nza2_q) begin
      if (nzb2_q) begin
        kind_d = nzc2_q ? KIND_ALL : KIND_NONE;
      end else begin
        kind_d = nzc2_q ? KIND_LIN_ZERO : KIND_LIN;
      end
    end else if (dzero) begin
      kind_d = KIND_ONE;
    end else if (d2_q[D_W-1]) begin
      kind_d = KIND_NONE;
    end else begin
      kind_d = KIND_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q        <= coef_square_i;
      b1_q        <= coef_linear_i;
      c1_q        <= coef_free_i;
      ac1_q       <= coef_square_i * coef_free_i;
      bb1_q       <= coef_linear_i * coef_linear_i;
      nza1_q      <= near_zero(coef_square_i, tol_i);
      nzb1_q      <= near_zero(coef_linear_i, tol_i);
      nzc1_q      <= near_zero(coef_free_i, tol_i);
      a2_q        <= a1_q;
      b2_q        <= b1_q;
      c2_q        <= c1_q;
      nza2_q      <= nza1_q;
      nzb2_q      <= nzb1_q;
      nzc2_q      <= nzc1_q;
      d2_q        <= D_W'(bb1_q) - (D_W'(ac1_q) <<< 2);
      item_q.kind <= kind_d;
      item_q.a    <= a2_q;
      item_q.b    <= b2_q;
      item_q.c    <= c2_q;
      item_q.rad  <= d2_q;
    end
  end

  assign valid_o = v3_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[sv/qrs_fifo.sv]
// Two-entry queue between the front end and the back end.
// Depends on qrs_pkg.
`default_nettype none

module qrs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qrs_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output qrs_pkg::item_t item_o
);
  import qrs_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

[sv/qrs_sqrt.sv]
// Pipelined integer square root, one root bit per stage; carries the transaction.
// Depends on qrs_pkg.
`default_nettype none

module qrs_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  qrs_pkg::item_t           item_i,
  output logic                     valid_o,
  output qrs_pkg::item_t           item_o,
  output logic [qrs_pkg::SQ_W-1:0] root_o
);
  import qrs_pkg::*;

  logic             v_q    [SQ_W+1];
  item_t            it_q   [SQ_W+1];
  logic [SQR_W-1:0] rem_q  [SQ_W+1];
  logic [SQ_W-1:0]  root_q [SQ_W+1];
  logic [D_W-1:0]   rad_q  [SQ_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q[0]   <= item_i;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    rad_q[0]  <= item_i.rad;
  end

  for (genvar k = 1; k <= SQ_W; k++) begin : g_stage
    localparam int T_W = SQR_W + 2;
    logic [T_W-1:0] t, trial;
    logic           ge;

    assign t     = {rem_q[k-1], rad_q[k-1][D_W-1 -: 2]};
    assign trial = T_W'({root_q[k-1], 2'b01});
    assign ge    = t >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      it_q[k]   <= it_q[k-1];
      rem_q[k]  <= ge ? SQR_W'(t - trial) : SQR_W'(t);
      root_q[k] <= {root_q[k-1][SQ_W-2:0], ge};
      rad_q[k]  <= rad_q[k-1] << 2;
    end
  end

  assign valid_o = v_q[SQ_W];
  assign item_o  = it_q[SQ_W];
  assign root_o  = root_q[SQ_W];

endmodule

`default_nettype wire

[sv/qrs_div.sv]
// Pipelined signed fixed-point divider, one quotient bit per stage, with saturation.
// Depends on qrs_pkg.
`default_nettype none

module qrs_div (
  input  logic                            clk_i,
  input  logic signed [qrs_pkg::NUM_W-1:0] num_i,
  input  logic signed [qrs_pkg::DEN_W-1:0] den_i,
  output logic [qrs_pkg::VW-1:0]           quo_o,
  output logic                             ovf_o
);
  import qrs_pkg::*;

  logic [NMAG_W-1:0] nmag;
  logic [DMAG_W-1:0] dmag;
  logic [NM_W-1:0]   nm;

  logic [REM_W-1:0]  rem_q  [QB+1];
  logic [QB-1:0]     low_q  [QB+1];
  logic [QB-1:0]     q_q    [QB+1];
  logic [DMAG_W-1:0] dm_q   [QB+1];
  logic              neg_q  [QB+1];
  logic              nneg_q [QB+1];
  logic              dz_q   [QB+1];
  logic              big_q  [QB+1];

  logic [VW-1:0] quo_d, quo_q;
  logic          ovf_d, ovf_q;
  logic [QB-1:0] q;

  always_comb begin
    nmag = num_i[NUM_W-1] ? NMAG_W'(-num_i) : NMAG_W'(num_i);
    dmag = den_i[DEN_W-1] ? DMAG_W'(-den_i) : DMAG_W'(den_i);
    nm   = {nmag, {FB{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= REM_W'(nm >> QB);
    low_q[0]  <= nm[QB-1:0];
    q_q[0]    <= '0;
    dm_q[0]   <= dmag;
    neg_q[0]  <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
    nneg_q[0] <= num_i[NUM_W-1];
    dz_q[0]   <= dmag == '0;
    big_q[0]  <= CMP_W'(nm) >= (CMP_W'(dmag) << QB);
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [REM_W-1:0] t;
    logic             ge;

    assign t  = {rem_q[k-1][REM_W-2:0], low_q[k-1][QB-1]};
    assign ge = t >= REM_W'(dm_q[k-1]);

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? t - REM_W'(dm_q[k-1]) : t;
      low_q[k]  <= low_q[k-1] << 1;
      q_q[k]    <= {q_q[k-1][QB-2:0], ge};
      dm_q[k]   <= dm_q[k-1];
      neg_q[k]  <= neg_q[k-1];
      nneg_q[k] <= nneg_q[k-1];
      dz_q[k]   <= dz_q[k-1];
      big_q[k]  <= big_q[k-1];
    end
  end

  assign q = q_q[QB];

  always_comb begin
    ovf_d = 1'b0;
    quo_d = q[VW-1:0];
    if (dz_q[QB]) begin
      ovf_d = 1'b1;
      quo_d = nneg_q[QB] ? VAL_MIN : VAL_MAX;
    end else if (big_q[QB]) begin
      ovf_d = 1'b1;
      quo_d = neg_q[QB] ? VAL_MIN : VAL_MAX;
    end else if (!neg_q[QB]) begin
      if (q > QB'(VAL_MAX)) begin
        ovf_d = 1'b1;
        quo_d = VAL_MAX;
      end
    end else if (q > QB'(VAL_MIN)) begin
      ovf_d = 1'b1;
      quo_d = VAL_MIN;
    end else begin
      quo_d = VW'(-q);
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign quo_o = quo_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

[sv/qrs_back.sv]
// Back end: square root, operand setup, two dividers and result formatting.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
`default_nettype none

module qrs_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  qrs_pkg::item_t            item_i,
  input  logic [qrs_pkg::TOL_W-1:0] tol_i,
  output logic                      pop_o,
  output qrs_pkg::result_t          res_o
);
  import qrs_pkg::*;

  logic                    sq_valid;
  item_t                   sq_item;
  logic [SQ_W-1:0]         sq_root;
  logic signed [NUM_W-1:0] b_ext, c_ext, s_ext;
  logic signed [DEN_W-1:0] a2_ext, b_den;
  logic signed [NUM_W-1:0] num_hi_d, num_lo_d, num_hi_q, num_lo_q;
  logic signed [DEN_W-1:0] den_d, den_q;
  logic                    sv_q;
  kind_e                   skind_q;
  logic                    kv_q [DIV_LAT];
  kind_e                   kk_q [DIV_LAT];
  logic [VW-1:0]           quo_hi, quo_lo;
  logic                    ovf_hi, ovf_lo;
  result_t                 res_d, res_q;

  assign pop_o = valid_i;

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .item_i  (item_i),
    .valid_o (sq_valid),
    .item_o  (sq_item),
    .root_o  (sq_root)
  );

  always_comb begin
    b_ext  = NUM_W'(sq_item.b);
    c_ext  = NUM_W'(sq_item.c);
    s_ext  = NUM_W'(sq_root);
    a2_ext = DEN_W'(sq_item.a) <<< 1;
    b_den  = DEN_W'(sq_item.b);
    case (sq_item.kind)
      KIND_LIN: begin
        num_hi_d = -c_ext;
        num_lo_d = -c_ext;
        den_d    = b_den;
      end
      KIND_ONE: begin
        num_hi_d = -b_ext;
        num_lo_d = -b_ext;
        den_d    = a2_ext;
      end
      KIND_TWO: begin
        num_hi_d = s_ext - b_ext;
        num_lo_d = -b_ext - s_ext;
        den_d    = a2_ext;
      end
      default: begin
        num_hi_d = '0;
        num_lo_d = '0;
        den_d    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else begin
      sv_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    skind_q  <= sq_item.kind;
    num_hi_q <= num_hi_d;
    num_lo_q <= num_lo_d;
    den_q    <= den_d;
  end

  qrs_div u_div_hi (
    .clk_i (clk_i),
    .num_i (num_hi_q),
    .den_i (den_q),
    .quo_o (quo_hi),
    .ovf_o (ovf_hi)
  );

  qrs_div u_div_lo (
    .clk_i (clk_i),
    .num_i (num_lo_q),
    .den_i (den_q),
    .quo_o (quo_lo),
    .ovf_o (ovf_lo)
  );

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        kv_q[k] <= 1'b0;
      end else if (k == 0) begin
        kv_q[k] <= sv_q;
      end else begin
        kv_q[k] <= kv_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      kk_q[k] <= (k == 0) ? skind_q : kk_q[(k == 0) ? 0 : k-1];
    end
  end

  always_comb begin
    res_d       = '0;
    res_d.valid = kv_q[DIV_LAT-1];
    case (kk_q[DIV_LAT-1])
      KIND_ALL: begin
        res_d.count = CNT_ALL;
      end
      KIND_LIN_ZERO: begin
        res_d.count = CNT_ONE;
      end
      KIND_LIN: begin
        res_d.count = CNT_ONE;
        res_d.hi    = quo_hi;
        res_d.lo    = quo_hi;
        res_d.ovf   = ovf_hi;
      end
      KIND_ONE: begin
        res_d.count = CNT_ONE;
        res_d.hi    = near_zero(quo_hi, tol_i) ? '0 : quo_hi;
        res_d.lo    = res_d.hi;
        res_d.ovf   = ovf_hi;
      end
      KIND_TWO: begin
        res_d.count = CNT_TWO;
        res_d.hi    = quo_hi;
        res_d.lo    = quo_lo;
        res_d.ovf   = ovf_hi | ovf_lo;
      end
      default: begin
        res_d.count = CNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[sv/quadratic_root_solver_unit.sv]
// Quadratic root solver top level: config register, front end, queue, back end.
// Depends on qrs_pkg, qrs_front, qrs_fifo and qrs_back.
//
// channel   direction  handshake            payload
// config    in         cfg_we_i             cfg_wdata_i (zero tolerance)
// command   in         start & !busy        coef_square_i, coef_linear_i, coef_free_i
// result    out        done_o (one cycle)   root_count_o, root_high_o, root_low_o,
//                                           overflow_flag_o
//
// One transaction per cycle; done_o follows acceptance through front end, queue and back end,
// whose 33-stage square root and 32-stage dividers make up most of the pipeline.
// Reset clears the pipeline valids and loads a tolerance of 1.
// The back end never stalls, so the queue drains every cycle and busy stays low;
// results cannot be held off by the receiver.
`default_nettype none

module quadratic_root_solver_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qrs_pkg::TOL_W-1:0]     cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [qrs_pkg::VW-1:0] coef_square_i,
  input  logic signed [qrs_pkg::VW-1:0] coef_linear_i,
  input  logic signed [qrs_pkg::VW-1:0] coef_free_i,
  output logic                          done_o,
  output logic [1:0]                    root_count_o,
  output logic signed [qrs_pkg::VW-1:0] root_high_o,
  output logic signed [qrs_pkg::VW-1:0] root_low_o,
  output logic                          overflow_flag_o
);
  import qrs_pkg::*;

  logic [TOL_W-1:0] tol_q;
  logic             accept;
  logic             fr_valid;
  item_t            fr_item;
  logic             fifo_full, fifo_valid, fifo_pop;
  item_t            fifo_item;
  result_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  assign busy   = fifo_full;
  assign accept = start && !busy;

  qrs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .coef_square_i (coef_square_i),
    .coef_linear_i (coef_linear_i),
    .coef_free_i   (coef_free_i),
    .tol_i         (tol_q),
    .stall_i       (fifo_full),
    .valid_o       (fr_valid),
    .item_o        (fr_item)
  );

  qrs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .item_i  (fr_item),
    .pop_i   (fifo_pop),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .item_o  (fifo_item)
  );

  qrs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fifo_valid),
    .item_i  (fifo_item),
    .tol_i   (tol_q),
    .pop_o   (fifo_pop),
    .res_o   (res)
  );

  assign done_o          = res.valid;
  assign root_count_o    = res.count;
  assign root_high_o     = res.hi;
  assign root_low_o      = res.lo;
  assign overflow_flag_o = res.ovf;

  a_queue_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_full)
    else $error("queue filled although the back end drains every cycle");

  a_no_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (root_count_o == CNT_NONE || root_count_o == CNT_ALL) |->
      root_high_o == '0 && root_low_o == '0 && !overflow_flag_o)
    else $error("nonzero root fields with no single root set");

  a_one_root_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && root_count_o == CNT_ONE |-> root_high_o == root_low_o)
    else $error("single root differs between root fields");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for quadratic_root_solver_unit: a queue-fed driver and a
// result monitor, scored against a built-in model of the root computation.
// Depends on qrs_pkg and the quadratic_root_solver_unit RTL.
`timescale 1ns / 1ps

module tb_top;
  import qrs_pkg::*;

  typedef struct {
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
    logic signed [VW-1:0] c;
  } coef_set_t;

  typedef struct {
    logic [1:0]    count;
    logic [VW-1:0] hi;
    logic [VW-1:0] lo;
    logic          ovf;
  } roots_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [TOL_W-1:0]     cfg_wdata_i = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [VW-1:0] coef_square_i = '0;
  logic signed [VW-1:0] coef_linear_i = '0;
  logic signed [VW-1:0] coef_free_i = '0;
  logic                 done_o;
  logic [1:0]           root_count_o;
  logic signed [VW-1:0] root_high_o;
  logic signed [VW-1:0] root_low_o;
  logic                 overflow_flag_o;

  coef_set_t pending_q[$];
  roots_t    roots_q[$];
  longint    tol_copy = 1;
  int        n_errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        count_seen[4] = '{0, 0, 0, 0};
  int        n_ovf = 0;
  int        idle_cnt = 0;
  int        stall_left = 0;
  int        stall_max = 10;
  int        watchdog = 0;

  always #5 clk_i = ~clk_i;

  quadratic_root_solver_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start           (start),
    .busy            (busy),
    .coef_square_i   (coef_square_i),
    .coef_linear_i   (coef_linear_i),
    .coef_free_i     (coef_free_i),
    .done_o          (done_o),
    .root_count_o    (root_count_o),
    .root_high_o     (root_high_o),
    .root_low_o      (root_low_o),
    .overflow_flag_o (overflow_flag_o)
  );

  function automatic bit is_zeroish(longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    return mag < tol_copy;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned m);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > m) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (m >= res + bitv) begin
        m = m - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint fixed_quotient(longint num, longint den, inout bit ovf);
    longint unsigned nm, dm, q;
    bit neg;
    if (den == 0) begin
      ovf = 1'b1;
      return (num < 0) ? -(64'sd1 <<< (VW - 1)) : longint'(VAL_MAX);
    end
    nm = longint'((num < 0) ? -num : num);
    nm = nm << FB;
    dm = longint'((den < 0) ? -den : den);
    q = nm / dm;
    neg = (num < 0) != (den < 0);
    if (!neg) begin
      if (q > longint'(VAL_MAX)) begin
        ovf = 1'b1;
        return longint'(VAL_MAX);
      end
      return longint'(q);
    end
    if (q > (64'd1 << (VW - 1))) begin
      ovf = 1'b1;
      q = 64'd1 << (VW - 1);
    end
    return -longint'(q);
  endfunction

  function automatic roots_t solve_roots(coef_set_t s);
    roots_t r;
    longint a, b, c, hi, lo, quarter, m, d, slack, sq;
    longint unsigned bm, b2, rem, dmag, t;
    bit ovf, d_zero;
    a = s.a;
    b = s.b;
    c = s.c;
    hi = 0;
    lo = 0;
    ovf = 1'b0;
    r.count = CNT_NONE;
    if (is_zeroish(a)) begin
      if (is_zeroish(b)) begin
        r.count = is_zeroish(c) ? CNT_ALL : CNT_NONE;
      end else begin
        r.count = CNT_ONE;
        hi = is_zeroish(c) ? 0 : fixed_quotient(-c, b, ovf);
        lo = hi;
      end
    end else begin
      bm = longint'((b < 0) ? -b : b);
      b2 = bm * bm;
      quarter = longint'(b2 >> 2);
      rem = b2 & 64'd3;
      m = quarter - a * c;
      d_zero = 1'b0;
      if (m > -(64'sd1 <<< 50) && m < (64'sd1 <<< 50)) begin
        d = m * 4 + longint'(rem);
        dmag = longint'((d < 0) ? -d : d);
        d_zero = dmag < (longint'(tol_copy) << FB);
      end
      if (d_zero) begin
        r.count = CNT_ONE;
        hi = fixed_quotient(-b, 2 * a, ovf);
        if (is_zeroish(hi)) hi = 0;
        lo = hi;
      end else if (m < 0) begin
        r.count = CNT_NONE;
      end else begin
        t = floor_sqrt(longint'(m));
        slack = m - longint'(t * t) - longint'(t);
        sq = longint'(2 * t);
        if (slack >= ((rem != 0) ? 0 : 1)) sq = sq + 1;
        r.count = CNT_TWO;
        hi = fixed_quotient(-b + sq, 2 * a, ovf);
        lo = fixed_quotient(-b - sq, 2 * a, ovf);
      end
    end
    r.hi = hi[VW-1:0];
    r.lo = lo[VW-1:0];
    r.ovf = ovf;
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    coef_set_t nxt;
    coef_set_t cur;
    if (!rst_ni) begin
      start <= 1'b0;
      stall_left <= 0;
    end else begin
      if (start && !busy) begin
        cur.a = coef_square_i;
        cur.b = coef_linear_i;
        cur.c = coef_free_i;
        roots_q.push_back(solve_roots(cur));
        n_sent++;
        idle_cnt++;
        if (idle_cnt % 60 == 0) stall_max <= (stall_max == 0) ? 10 : 0;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        coef_square_i <= nxt.a;
        coef_linear_i <= nxt.b;
        coef_free_i <= nxt.c;
        start <= 1'b1;
        stall_left <= $urandom_range(0, stall_max);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    roots_t e;
    if (rst_ni && done_o) begin
      if (roots_q.size() == 0) begin
        $error("result transaction with nothing expected");
        n_errors++;
      end else begin
        e = roots_q.pop_front();
        n_checked++;
        count_seen[e.count]++;
        if (e.ovf) n_ovf++;
        if (root_count_o !== e.count) begin
          $error("root_count expected %0d got %0d", e.count, root_count_o);
          n_errors++;
        end
        if (root_high_o !== e.hi) begin
          $error("root_high expected %h got %h", e.hi, root_high_o);
          n_errors++;
        end
        if (root_low_o !== e.lo) begin
          $error("root_low expected %h got %h", e.lo, root_low_o);
          n_errors++;
        end
        if (overflow_flag_o !== e.ovf) begin
          $error("overflow_flag expected %0d got %0d", e.ovf, overflow_flag_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", watchdog);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [VW-1:0] near_tol();
    int unsigned mag;
    mag = $urandom_range(0, 2 * int'(tol_copy) + 2);
    return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [VW-1:0] mid_val();
    return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
  endfunction

  task automatic push_set(logic signed [VW-1:0] a, logic signed [VW-1:0] b,
                          logic signed [VW-1:0] c);
    coef_set_t s;
    s.a = a;
    s.b = b;
    s.c = c;
    pending_q.push_back(s);
  endtask

  task automatic push_random(int n);
    int k;
    logic signed [VW-1:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: push_set($urandom, $urandom, $urandom);
        2: push_set(near_tol(), near_tol(), near_tol());
        3: push_set(near_tol(), mid_val(), mid_val());
        4: push_set(near_tol(), near_tol(), mid_val());
        5: begin
          k = $urandom_range(0, 255);
          v = $signed(k * 256) * ($urandom_range(0, 1) ? -1 : 1);
          if ($urandom_range(0, 1)) push_set(32'sh0001_0000, 2 * v, k * k);
          else push_set(-32'sh0001_0000, 2 * v, -(k * k));
        end
        6, 7: push_set(mid_val(), mid_val(), mid_val());
        8: push_set($signed($urandom_range(1, 300)) * ($urandom_range(0, 1) ? -1 : 1),
                    $urandom, mid_val());
        default: push_set($urandom, mid_val(), near_tol());
      endcase
    end
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || start || roots_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    tol_copy = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    push_set(0, 0, 0);
    push_set(0, 0, 5);
    push_set(0, 32'sh0001_0000, -32'sh0002_0000);
    push_set(0, 32'sh0003_0000, 0);
    push_set(0, 1, 32'sh7FFF_FFFF);
    push_set(0, -1, 32'sh8000_0000);
    push_set(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000);
    push_set(32'sh0001_0000, 0, 32'sh0001_0000);
    push_set(32'sh0001_0000, 0, -32'sh0004_0000);
    push_set(1, 32'sh7FFF_FFFF, 0);
    push_set(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    push_set(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_set(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    push_set(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
    push_set(-1, 32'sh0000_0100, 1);
    push_set(32'sh0000_0001, 0, 0);
    push_set(32'sh0002_0000, -32'sh0006_0000, 32'sh0004_0000);
    push_random(160);
    drain();
    set_tolerance(16'd0);
    push_set(0, 0, 0);
    push_set(0, 0, 5);
    push_set(0, 0, -5);
    push_set(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000);
    push_random(160);
    drain();
    set_tolerance(16'hFFFF);
    push_set(32'sh0000_FFFE, 32'sh0000_FFFF, 32'sh0001_0000);
    push_set(32'sh0001_0000, 32'sh0000_0100, 0);
    push_random(160);
    drain();
    set_tolerance(16'd16);
    push_random(170);
    drain();
    set_tolerance($urandom);
    push_random(170);
    drain();
    set_tolerance(16'd1);
    push_random(170);
    drain();
    $display("%0d coefficient sets sent, %0d results checked over six tolerance settings",
             n_sent, n_checked);
    $display("root counts none/one/two/all: %0d/%0d/%0d/%0d, saturated: %0d",
             count_seen[0], count_seen[1], count_seen[2], count_seen[3], n_ovf);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/qrs_pkg.sv
sv/qrs_front.sv
sv/qrs_fifo.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/qrs_back.sv
sv/quadratic_root_solver_unit.sv
tb/tb_top.sv
